### src/assert_macros.svh
// assertion macros for the checker file awr_checker.sv
// no dependencies; expects clock and reset in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_SYNC(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

### src/awr_pkg.sv
// types, constants and arithmetic helpers for the arena wall reflection block
// no dependencies
package awr_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int NORM_BITS  = 30;
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 31;

   // register index of each pipeline stage
   localparam int ST_SQ0  = 2;
   localparam int ST_D    = ST_SQ0 + SQRT_STEPS + 1;
   localparam int ST_E    = ST_D + DIV_STEPS + 1;
   localparam int ST_F    = ST_E + 1;
   localparam int ST_G    = ST_F + 1;
   localparam int ST_H    = ST_G + 1;
   localparam int ST_I    = ST_H + 1;
   localparam int ST_J    = ST_I + 1;
   localparam int ST_LAST = ST_J + 1;

   typedef enum logic [1:0] {
      REG_SHAPE  = 2'd0,
      REG_WIDTH  = 2'd1,
      REG_HEIGHT = 2'd2,
      REG_RING   = 2'd3
   } csr_reg_type;

   localparam logic        RST_SHAPE  = 1'b0;
   localparam logic [14:0] RST_WIDTH  = 15'd1024;
   localparam logic [14:0] RST_HEIGHT = 15'd768;
   localparam logic [14:0] RST_RING   = 15'd512;

   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic [30:0]        r;
      logic               ring_hit;
      logic               center;
      logic signed [34:0] breach;
   } item_type;

   function automatic logic [31:0] abs32(input logic signed [31:0] x);
      return x[31] ? 32'(-x) : 32'(x);
   endfunction

   function automatic logic signed [31:0] neg_sat(input logic signed [31:0] x);
      return (x == 32'sh80000000) ? 32'sh7fffffff : -x;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [37:0] x);
      logic signed [31:0] res;
      if (x > 38'sd2147483647) begin
         res = 32'sh7fffffff;
      end else if (x < -38'sd2147483648) begin
         res = 32'sh80000000;
      end else begin
         res = x[31:0];
      end
      return res;
   endfunction

   // divide by 2^NORM_BITS, nearest, ties away from zero
   function automatic logic signed [36:0] round30(input logic signed [66:0] x);
      logic signed [66:0] t;
      t = x + (67'sd1 <<< (NORM_BITS - 1)) - $signed(67'(x[66]));
      return 37'(t >>> NORM_BITS);
   endfunction

endpackage

### src/arena_wall_reflection.sv
// arena wall reflection: box or ring bounce of one particle per item
// depends on awr_pkg
//
// one req item is accepted per cycle unless a finished rsp item is held unclaimed
// the pipe holds the 32 one-step square root stages and the 31 one-bit divider stages
// a held rsp item freezes every stage; nothing is dropped or repeated
// reset (synchronous, active high) clears all valid bits and restores the csr registers
module arena_wall_reflection (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [159:0] req_tdata,   // pos_x, pos_y, vel_x, vel_y, particle_radius, pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // new_pos_x, new_pos_y, new_vel_x, new_vel_y
   output logic         rsp_tuser,   // bounced
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [14:0]  csr_data
);

   localparam int LAST = awr_pkg::ST_LAST;
   localparam int SQN  = awr_pkg::SQRT_STEPS;
   localparam int DVN  = awr_pkg::DIV_STEPS;

   // configuration registers
   logic        shape_ff;
   logic [14:0] width_ff;
   logic [14:0] height_ff;
   logic [14:0] ring_ff;

   // valid bits and the item that rides along every stage
   logic               vld_ff  [0:LAST];
   awr_pkg::item_type  item_ff [0:LAST-1];
   awr_pkg::item_type  item_in [0:LAST-1];
   logic               adv;

   // squares and square root
   logic [63:0] b_sqx_ff, b_sqy_ff;
   logic [63:0] sq_v_ff [0:SQN];
   logic [63:0] sq_r_ff [0:SQN];
   logic [63:0] sq_v_in [1:SQN];
   logic [63:0] sq_r_in [1:SQN];

   // normal divider, one quotient bit per stage
   logic [31:0] dv_dist_ff [0:DVN-1];
   logic [31:0] dv_rx_ff   [0:DVN];
   logic [31:0] dv_ry_ff   [0:DVN];
   logic [30:0] dv_qx_ff   [0:DVN];
   logic [30:0] dv_qy_ff   [0:DVN];
   logic [31:0] dv_rx_in   [1:DVN];
   logic [31:0] dv_ry_in   [1:DVN];
   logic [30:0] dv_qx_in   [1:DVN];
   logic [30:0] dv_qy_in   [1:DVN];
   logic        dv_lsbx_ff, dv_lsby_ff;

   logic [31:0]        d_dist;
   logic [31:0]        d_ax, d_ay;
   logic signed [34:0] d_breach;
   logic [34:0]        ring_fx;
   logic [33:0]        width_fx, height_fx;
   logic [31:0]        a_ax, a_ay;

   // back end
   logic signed [31:0] e_nx_ff, e_ny_ff;
   logic signed [63:0] f_pvx_ff, f_pvy_ff;
   logic signed [66:0] f_pbx_ff, f_pby_ff;
   logic signed [31:0] f_nx_ff, f_ny_ff;
   logic signed [63:0] g_s_ff;
   logic signed [36:0] g_rbx_ff, g_rby_ff;
   logic signed [31:0] g_nx_ff, g_ny_ff;
   logic signed [34:0] h_vn_ff;
   logic signed [31:0] h_rpx_ff, h_rpy_ff, h_nx_ff, h_ny_ff;
   logic signed [33:0] h_bl_ff, h_br_ff, h_bt_ff, h_bb_ff;
   logic signed [66:0] i_pnx_ff, i_pny_ff;
   logic signed [31:0] i_rpx_ff, i_rpy_ff;
   logic signed [31:0] i_bpx_ff, i_bpy_ff, i_bvx_ff, i_bvy_ff;
   logic               i_bhit_ff;
   logic signed [36:0] j_rnx_ff, j_rny_ff;
   logic signed [31:0] j_rpx_ff, j_rpy_ff;
   logic signed [31:0] j_bpx_ff, j_bpy_ff, j_bvx_ff, j_bvy_ff;
   logic               j_bhit_ff;

   logic signed [31:0] i_bpx_in, i_bpy_in, i_bvx_in, i_bvy_in;
   logic               i_bhit_in;
   logic signed [31:0] o_px_ff, o_py_ff, o_vx_ff, o_vy_ff;
   logic               o_hit_ff;
   logic signed [31:0] o_px_in, o_py_in, o_vx_in, o_vy_in;
   logic               o_hit_in;

   // whole pipe moves unless a finished item sits unclaimed at the output
   assign adv        = !vld_ff[LAST] || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = vld_ff[LAST];
   assign rsp_tdata  = {o_vy_ff, o_vx_ff, o_py_ff, o_px_ff};
   assign rsp_tuser  = o_hit_ff;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         shape_ff  <= awr_pkg::RST_SHAPE;
         width_ff  <= awr_pkg::RST_WIDTH;
         height_ff <= awr_pkg::RST_HEIGHT;
         ring_ff   <= awr_pkg::RST_RING;
      end else if (csr_valid) begin
         unique case (csr_index)
            awr_pkg::REG_SHAPE:  shape_ff  <= csr_data[0];
            awr_pkg::REG_WIDTH:  width_ff  <= csr_data;
            awr_pkg::REG_HEIGHT: height_ff <= csr_data;
            awr_pkg::REG_RING:   ring_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // wall positions in fixed point
   assign ring_fx   = 35'(ring_ff) << awr_pkg::FRAC_BITS;
   assign width_fx  = 34'(width_ff) << awr_pkg::FRAC_BITS;
   assign height_fx = 34'(height_ff) << awr_pkg::FRAC_BITS;

   // front: magnitudes for the squares
   assign a_ax = awr_pkg::abs32(item_ff[0].px);
   assign a_ay = awr_pkg::abs32(item_ff[0].py);

   // ring breach once the distance is known
   assign d_dist   = sq_r_ff[SQN][31:0];
   assign d_breach = $signed({3'b0, d_dist}) + $signed({4'b0, item_ff[awr_pkg::ST_D-1].r})
                     - $signed(ring_fx);
   assign d_ax     = awr_pkg::abs32(item_ff[awr_pkg::ST_D-1].px);
   assign d_ay     = awr_pkg::abs32(item_ff[awr_pkg::ST_D-1].py);

   always_comb begin
      item_in[0].px       = req_tdata[31:0];
      item_in[0].py       = req_tdata[63:32];
      item_in[0].vx       = req_tdata[95:64];
      item_in[0].vy       = req_tdata[127:96];
      item_in[0].r        = req_tdata[158:128];
      item_in[0].ring_hit = 1'b0;
      item_in[0].center   = 1'b0;
      item_in[0].breach   = '0;
      for (int i = 1; i < LAST; i++) begin
         item_in[i] = item_ff[i-1];
      end
      item_in[awr_pkg::ST_D].ring_hit = d_breach > 0;
      item_in[awr_pkg::ST_D].center   = d_dist == '0;
      item_in[awr_pkg::ST_D].breach   = d_breach;
   end

   // square root, one result bit per stage
   always_comb begin
      logic [63:0] bitv;
      logic [63:0] trial;
      for (int k = 0; k < SQN; k++) begin
         bitv  = 64'(1) << (2 * SQN - 2 - 2 * k);
         trial = sq_r_ff[k] + bitv;
         if (sq_v_ff[k] >= trial) begin
            sq_v_in[k+1] = sq_v_ff[k] - trial;
            sq_r_in[k+1] = (sq_r_ff[k] >> 1) + bitv;
         end else begin
            sq_v_in[k+1] = sq_v_ff[k];
            sq_r_in[k+1] = sq_r_ff[k] >> 1;
         end
      end
   end

   // restoring division |p| * 2^30 / dist for both axes
   always_comb begin
      logic [32:0] tx, ty, dd;
      for (int j = 1; j <= DVN; j++) begin
         dd = {1'b0, dv_dist_ff[j-1]};
         tx = {dv_rx_ff[j-1], (j == 1) ? dv_lsbx_ff : 1'b0};
         ty = {dv_ry_ff[j-1], (j == 1) ? dv_lsby_ff : 1'b0};
         if (tx >= dd) begin
            dv_rx_in[j] = 32'(tx - dd);
         end else begin
            dv_rx_in[j] = tx[31:0];
         end
         if (ty >= dd) begin
            dv_ry_in[j] = 32'(ty - dd);
         end else begin
            dv_ry_in[j] = ty[31:0];
         end
         dv_qx_in[j] = {dv_qx_ff[j-1][29:0], tx >= dd};
         dv_qy_in[j] = {dv_qy_ff[j-1][29:0], ty >= dd};
      end
   end

   // box bounce from the stored breaches
   always_comb begin
      awr_pkg::item_type it;
      it        = item_ff[awr_pkg::ST_I-1];
      i_bhit_in = 1'b0;
      i_bpx_in  = it.px;
      i_bvx_in  = it.vx;
      i_bpy_in  = it.py;
      i_bvy_in  = it.vy;
      // low side wins over high side
      if (h_bl_ff < 0) begin
         i_bpx_in  = awr_pkg::sat32(38'(it.px) - (38'(h_bl_ff) <<< 1));
         i_bvx_in  = awr_pkg::neg_sat(it.vx);
         i_bhit_in = 1'b1;
      end else if (h_br_ff > 0) begin
         i_bpx_in  = awr_pkg::sat32(38'(it.px) - (38'(h_br_ff) <<< 1));
         i_bvx_in  = awr_pkg::neg_sat(it.vx);
         i_bhit_in = 1'b1;
      end
      if (h_bt_ff < 0) begin
         i_bpy_in  = awr_pkg::sat32(38'(it.py) - (38'(h_bt_ff) <<< 1));
         i_bvy_in  = awr_pkg::neg_sat(it.vy);
         i_bhit_in = 1'b1;
      end else if (h_bb_ff > 0) begin
         i_bpy_in  = awr_pkg::sat32(38'(it.py) - (38'(h_bb_ff) <<< 1));
         i_bvy_in  = awr_pkg::neg_sat(it.vy);
         i_bhit_in = 1'b1;
      end
   end

   // final select between box, ring and pass-through
   always_comb begin
      awr_pkg::item_type it;
      it       = item_ff[LAST-1];
      o_px_in  = it.px;
      o_py_in  = it.py;
      o_vx_in  = it.vx;
      o_vy_in  = it.vy;
      o_hit_in = 1'b0;
      if (!shape_ff) begin
         o_px_in  = j_bpx_ff;
         o_py_in  = j_bpy_ff;
         o_vx_in  = j_bvx_ff;
         o_vy_in  = j_bvy_ff;
         o_hit_in = j_bhit_ff;
      end else if (it.ring_hit) begin
         o_hit_in = 1'b1;
         if (it.center) begin
            // no normal at the exact center: flip both components
            o_vx_in = awr_pkg::neg_sat(it.vx);
            o_vy_in = awr_pkg::neg_sat(it.vy);
         end else begin
            o_px_in = j_rpx_ff;
            o_py_in = j_rpy_ff;
            o_vx_in = awr_pkg::sat32(38'(it.vx) - (38'(j_rnx_ff) <<< 1));
            o_vy_in = awr_pkg::sat32(38'(it.vy) - (38'(j_rny_ff) <<< 1));
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LAST; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i <= LAST; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < LAST; i++) begin
            item_ff[i] <= item_in[i];
         end
         b_sqx_ff <= 64'(a_ax) * 64'(a_ax);
         b_sqy_ff <= 64'(a_ay) * 64'(a_ay);

         sq_v_ff[0] <= b_sqx_ff + b_sqy_ff;
         sq_r_ff[0] <= '0;
         for (int k = 1; k <= SQN; k++) begin
            sq_v_ff[k] <= sq_v_in[k];
            sq_r_ff[k] <= sq_r_in[k];
         end

         dv_dist_ff[0] <= d_dist;
         dv_rx_ff[0]   <= d_ax >> 1;
         dv_ry_ff[0]   <= d_ay >> 1;
         dv_lsbx_ff    <= d_ax[0];
         dv_lsby_ff    <= d_ay[0];
         dv_qx_ff[0]   <= '0;
         dv_qy_ff[0]   <= '0;
         for (int j = 1; j < DVN; j++) begin
            dv_dist_ff[j] <= dv_dist_ff[j-1];
         end
         for (int j = 1; j <= DVN; j++) begin
            dv_rx_ff[j] <= dv_rx_in[j];
            dv_ry_ff[j] <= dv_ry_in[j];
            dv_qx_ff[j] <= dv_qx_in[j];
            dv_qy_ff[j] <= dv_qy_in[j];
         end

         // signed unit normal, Q1.30
         e_nx_ff <= item_ff[awr_pkg::ST_E-1].px[31] ? -$signed({1'b0, dv_qx_ff[DVN]})
                                                      : $signed({1'b0, dv_qx_ff[DVN]});
         e_ny_ff <= item_ff[awr_pkg::ST_E-1].py[31] ? -$signed({1'b0, dv_qy_ff[DVN]})
                                                      : $signed({1'b0, dv_qy_ff[DVN]});

         f_pvx_ff <= 64'(item_ff[awr_pkg::ST_F-1].vx) * 64'(e_nx_ff);
         f_pvy_ff <= 64'(item_ff[awr_pkg::ST_F-1].vy) * 64'(e_ny_ff);
         f_pbx_ff <= 67'(item_ff[awr_pkg::ST_F-1].breach) * 67'(e_nx_ff);
         f_pby_ff <= 67'(item_ff[awr_pkg::ST_F-1].breach) * 67'(e_ny_ff);
         f_nx_ff  <= e_nx_ff;
         f_ny_ff  <= e_ny_ff;

         g_s_ff   <= f_pvx_ff + f_pvy_ff;
         g_rbx_ff <= awr_pkg::round30(f_pbx_ff);
         g_rby_ff <= awr_pkg::round30(f_pby_ff);
         g_nx_ff  <= f_nx_ff;
         g_ny_ff  <= f_ny_ff;

         h_vn_ff  <= 35'(awr_pkg::round30(67'(g_s_ff)));
         h_rpx_ff <= awr_pkg::sat32(38'(item_ff[awr_pkg::ST_H-1].px) - (38'(g_rbx_ff) <<< 1));
         h_rpy_ff <= awr_pkg::sat32(38'(item_ff[awr_pkg::ST_H-1].py) - (38'(g_rby_ff) <<< 1));
         h_nx_ff  <= g_nx_ff;
         h_ny_ff  <= g_ny_ff;
         h_bl_ff  <= 34'(item_ff[awr_pkg::ST_H-1].px)
                     - $signed({3'b0, item_ff[awr_pkg::ST_H-1].r});
         h_br_ff  <= 34'(item_ff[awr_pkg::ST_H-1].px)
                     + $signed({3'b0, item_ff[awr_pkg::ST_H-1].r}) - $signed(width_fx);
         h_bt_ff  <= 34'(item_ff[awr_pkg::ST_H-1].py)
                     - $signed({3'b0, item_ff[awr_pkg::ST_H-1].r});
         h_bb_ff  <= 34'(item_ff[awr_pkg::ST_H-1].py)
                     + $signed({3'b0, item_ff[awr_pkg::ST_H-1].r}) - $signed(height_fx);

         i_pnx_ff  <= 67'(h_vn_ff) * 67'(h_nx_ff);
         i_pny_ff  <= 67'(h_vn_ff) * 67'(h_ny_ff);
         i_rpx_ff  <= h_rpx_ff;
         i_rpy_ff  <= h_rpy_ff;
         i_bpx_ff  <= i_bpx_in;
         i_bpy_ff  <= i_bpy_in;
         i_bvx_ff  <= i_bvx_in;
         i_bvy_ff  <= i_bvy_in;
         i_bhit_ff <= i_bhit_in;

         j_rnx_ff  <= awr_pkg::round30(i_pnx_ff);
         j_rny_ff  <= awr_pkg::round30(i_pny_ff);
         j_rpx_ff  <= i_rpx_ff;
         j_rpy_ff  <= i_rpy_ff;
         j_bpx_ff  <= i_bpx_ff;
         j_bpy_ff  <= i_bpy_ff;
         j_bvx_ff  <= i_bvx_ff;
         j_bvy_ff  <= i_bvy_ff;
         j_bhit_ff <= i_bhit_ff;

         o_px_ff  <= o_px_in;
         o_py_ff  <= o_py_in;
         o_vx_ff  <= o_vx_in;
         o_vy_ff  <= o_vy_in;
         o_hit_ff <= o_hit_in;
      end
   end

endmodule

### src/awr_checker.sv
// port-level checks for the arena wall reflection block, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module awr_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [159:0] req_tdata,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic         rsp_tuser,
   input logic         csr_valid,
   input logic         csr_ready,
   input logic [1:0]   csr_index,
   input logic [14:0]  csr_data
);

   `ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "rsp item valid right after reset")

   `ASSERT_SYNC(a_stall_link, req_tready == (!rsp_tvalid || rsp_tready), "input not tied to output stall")

   `ASSERT_SYNC(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled rsp item changed")

endmodule

bind arena_wall_reflection awr_checker u_awr_checker (.*);
